FILE: hdl/cvca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvca_pkg
// Shared types and constants for the core-voltage cap arbiter.
// ----------------------------------------------------------------------------
package cvca_pkg;

  localparam int MAX_BUSES_DEF = 8;
  localparam int MAX_STEPS_DEF = 8;
  localparam int BUS_W         = 8;   // width of the bus mask field
  localparam int STEP_TBL_W    = 128; // steps 0..7, 16 bits each

  localparam logic [15:0] NOMINAL_RESET = 16'd1200;

  // Configuration register indexes
  localparam logic [2:0] REG_NOMINAL    = 3'd0;
  localparam logic [2:0] REG_STEP_LOW   = 3'd1;
  localparam logic [2:0] REG_STEP_HIGH  = 3'd2;
  localparam logic [2:0] REG_BUS_COUNT  = 3'd3;
  localparam logic [2:0] REG_BUS_MASK   = 3'd4;

  // Event actions
  localparam logic [2:0] ACT_KERNEL_EN  = 3'd0;
  localparam logic [2:0] ACT_KERNEL_DIS = 3'd1;
  localparam logic [2:0] ACT_KERNEL_SET = 3'd2;
  localparam logic [2:0] ACT_USER_EN    = 3'd3;
  localparam logic [2:0] ACT_USER_DIS   = 3'd4;
  localparam logic [2:0] ACT_USER_SET   = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] level_mv;
  } cvca_evt_t;

  typedef struct packed {
    logic [2:0]  bus_index;
    logic [2:0]  step_index;
    logic [15:0] cap_mv;
    logic        last;
  } cvca_cmd_t;

  typedef struct packed {
    logic [15:0]           nominal_mv;
    logic [STEP_TBL_W-1:0] steps;
    logic [3:0]            bus_count;
    logic [BUS_W-1:0]      bus_present_mask;
  } cvca_cfg_t;

  // One re-evaluation's worth of rate commands, handed to the emitter
  typedef struct packed {
    logic [BUS_W-1:0] mask;
    logic             down;
    logic [2:0]       step_index;
    logic [15:0]      cap_mv;
  } cvca_batch_t;

endpackage

FILE: hdl/cvca_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvca_eval
// Requester state and cap evaluation: one event per cycle unless it must wait
// on a busy emitter, producing a batch of bus commands for the emitter.
// ----------------------------------------------------------------------------
module cvca_eval import cvca_pkg::*; #(
  parameter int MAX_BUSES = MAX_BUSES_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cvca_cfg_t   cfg,
  input  logic        evt_ok,
  input  cvca_evt_t   evt_q,
  input  logic        emit_free,
  output logic        fire,
  output logic        batch_load,
  output cvca_batch_t batch
);

  logic [7:0]  kernel_count, kernel_count_next;
  logic [7:0]  user_count, user_count_next;
  logic [15:0] kernel_level, kernel_level_next;
  logic [15:0] user_level, user_level_next;
  logic [15:0] cap_level, cap_level_next;
  logic [1:0]  active_requesters, active_requesters_next;

  logic        reeval;
  logic [15:0] target;
  logic [3:0]  nb;
  logic [2:0]  chosen;
  logic        stop;
  logic [15:0] step_v;
  logic [15:0] newcap;

  always_comb begin
    kernel_count_next      = kernel_count;
    user_count_next        = user_count;
    kernel_level_next      = kernel_level;
    user_level_next        = user_level;
    active_requesters_next = active_requesters;
    reeval                 = 1'b0;
    unique case (evt_q.action)
      ACT_KERNEL_EN: begin
        if (kernel_count != 8'hFF) begin
          kernel_count_next = kernel_count + 8'd1;
          if (kernel_count == 8'd0) begin
            if (active_requesters != 2'd3) active_requesters_next = active_requesters + 2'd1;
            reeval = 1'b1;
          end
        end
      end
      ACT_KERNEL_DIS: begin
        if (kernel_count != 8'd0) begin
          kernel_count_next = kernel_count - 8'd1;
          if (kernel_count == 8'd1) begin
            if (active_requesters != 2'd0) active_requesters_next = active_requesters - 2'd1;
            reeval = 1'b1;
          end
        end
      end
      ACT_KERNEL_SET: begin
        kernel_level_next = evt_q.level_mv;
        reeval            = 1'b1;
      end
      ACT_USER_EN: begin
        if (user_count != 8'hFF) begin
          user_count_next = user_count + 8'd1;
          if (user_count == 8'd0) begin
            if (active_requesters != 2'd3) active_requesters_next = active_requesters + 2'd1;
            reeval = 1'b1;
          end
        end
      end
      ACT_USER_DIS: begin
        if (user_count != 8'd0) begin
          user_count_next = user_count - 8'd1;
          if (user_count == 8'd1) begin
            if (active_requesters != 2'd0) active_requesters_next = active_requesters - 2'd1;
            reeval = 1'b1;
          end
        end
      end
      ACT_USER_SET: begin
        user_level_next = evt_q.level_mv;
        reeval          = 1'b1;
      end
      default: ;
    endcase
  end

  // Effective cap, bus count clamp and step rounding
  always_comb begin
    target = cfg.nominal_mv;
    if (kernel_count_next != 8'd0 && kernel_level_next < target) target = kernel_level_next;
    if (user_count_next != 8'd0 && user_level_next < target) target = user_level_next;

    nb = (cfg.bus_count > 4'(MAX_BUSES)) ? 4'(MAX_BUSES) : cfg.bus_count;

    // last step not above target; stops at a zero step
    chosen = 3'd0;
    stop   = 1'b0;
    for (int k = 0; k < MAX_STEPS; k++) begin
      step_v = cfg.steps[k*16 +: 16];
      if (!stop) begin
        if (step_v == 16'd0 || target < step_v) stop = 1'b1;
        else chosen = 3'(k);
      end
    end
    newcap = cfg.steps[{chosen, 4'd0} +: 16];

    cap_level_next   = cap_level;
    batch            = '0;
    batch.step_index = chosen;
    batch.cap_mv     = newcap;
    batch.down       = newcap < cap_level;
    if (reeval && target != cap_level && nb != 4'd0) begin
      cap_level_next = newcap;
      if (newcap != cap_level) begin
        for (int i = 0; i < MAX_BUSES; i++) begin
          batch.mask[i] = cfg.bus_present_mask[i] && (4'(i) < nb);
        end
      end
    end
  end

  // Events without commands never wait on the emitter
  assign fire       = evt_ok && (emit_free || batch.mask == '0);
  assign batch_load = fire && batch.mask != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_count      <= 8'd0;
      user_count        <= 8'd0;
      kernel_level      <= NOMINAL_RESET;
      user_level        <= NOMINAL_RESET;
      cap_level         <= NOMINAL_RESET;
      active_requesters <= 2'd0;
    end else if (fire) begin
      kernel_count      <= kernel_count_next;
      user_count        <= user_count_next;
      kernel_level      <= kernel_level_next;
      user_level        <= user_level_next;
      cap_level         <= cap_level_next;
      active_requesters <= active_requesters_next;
    end
  end

  a_active_tracks_counts: assert property (@(posedge clk) disable iff (rst)
    active_requesters == {1'b0, kernel_count != 8'd0} + {1'b0, user_count != 8'd0})
    else $error("active requester count out of step with reference counts");

  a_cap_only_on_event: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(cap_level))
    else $error("cap level moved without an event");

  a_batch_waits_for_emitter: assert property (@(posedge clk) disable iff (rst)
    batch_load |-> emit_free)
    else $error("command batch loaded over a busy emitter");

endmodule

FILE: hdl/cvca_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvca_emit
// Walks a batch's bus mask, one rate command per cycle unless cmd_stall holds
// the output register; lowest bus first if the cap drops, highest if it rises.
// ----------------------------------------------------------------------------
module cvca_emit import cvca_pkg::*; #(
  parameter int MAX_BUSES = MAX_BUSES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        batch_load,
  input  cvca_batch_t batch,
  output logic        emit_free,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  output cvca_cmd_t   cmd
);

  logic [MAX_BUSES-1:0] pend, pend_next, rest;
  logic                 down;
  logic [2:0]           step_index;
  logic [15:0]          cap_mv;
  logic [2:0]           sel_lo, sel_hi, sel;
  logic                 pop;

  always_comb begin
    sel_lo = 3'd0;
    sel_hi = 3'd0;
    for (int i = MAX_BUSES - 1; i >= 0; i--) begin
      if (pend[i]) sel_lo = 3'(i);
    end
    for (int i = 0; i < MAX_BUSES; i++) begin
      if (pend[i]) sel_hi = 3'(i);
    end
    sel = down ? sel_lo : sel_hi;
    for (int i = 0; i < MAX_BUSES; i++) begin
      rest[i] = pend[i] && (3'(i) != sel);
    end
  end

  assign pop       = (pend != '0) && (!cmd_valid || !cmd_stall);
  assign emit_free = (pend == '0) || (pop && rest == '0);

  always_comb begin
    pend_next = pend;
    if (batch_load) pend_next = batch.mask[MAX_BUSES-1:0];
    else if (pop) pend_next = rest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      cmd_valid <= 1'b0;
    end else begin
      pend <= pend_next;
      if (pop) cmd_valid <= 1'b1;
      else if (!cmd_stall) cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (batch_load) begin
      down       <= batch.down;
      step_index <= batch.step_index;
      cap_mv     <= batch.cap_mv;
    end
    if (pop) begin
      cmd.bus_index  <= sel;
      cmd.step_index <= step_index;
      cmd.cap_mv     <= cap_mv;
      cmd.last       <= rest == '0;
    end
  end

  a_pending_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (pend != '0 && !(cmd_valid && cmd_stall)) |=> cmd_valid)
    else $error("pending command not moved to output register");

  a_bus_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd.bus_index < 3'(MAX_BUSES - 1) || cmd.bus_index == 3'(MAX_BUSES - 1))
    else $error("bus index beyond bus table");

endmodule

FILE: hdl/core_voltage_cap_arbiter.sv
`timescale 1ns / 1ps
// Path: the first rate command of an event passes the input register,
// evaluation, the emitter's pending mask and the output register to reach cmd.
// Throughput: one event per cycle while no commands are pending; the emitter
// sends one command per unstalled cycle and stays busy until a batch is sent.
// Reset (synchronous): registers to defaults, counts zero, levels 1200 mV.
// ----------------------------------------------------------------------------
// core_voltage_cap_arbiter
// Arbitrates the core rail cap between kernel and user requesters and emits
// per-bus rate commands when the rounded cap changes.
// ----------------------------------------------------------------------------
module core_voltage_cap_arbiter import cvca_pkg::*; #(
  parameter int MAX_BUSES = MAX_BUSES_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        evt_valid,
  output logic        evt_stall,
  input  cvca_evt_t   evt,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  output cvca_cmd_t   cmd
);

  cvca_cfg_t   cfg;
  logic        evt_ok;
  cvca_evt_t   evt_q;
  logic        fire;
  logic        emit_free;
  logic        batch_load;
  cvca_batch_t batch;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_mv       <= NOMINAL_RESET;
      cfg.steps            <= '0;
      cfg.bus_count        <= 4'd0;
      cfg.bus_present_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOMINAL:   cfg.nominal_mv            <= cfg_data[15:0];
        REG_STEP_LOW:  cfg.steps[63:0]           <= cfg_data;
        REG_STEP_HIGH: cfg.steps[127:64]         <= cfg_data;
        REG_BUS_COUNT: cfg.bus_count             <= cfg_data[3:0];
        REG_BUS_MASK:  cfg.bus_present_mask      <= cfg_data[BUS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: holds the item until evaluation takes it
  assign evt_stall = evt_ok && !fire;

  always_ff @(posedge clk) begin
    if (rst) evt_ok <= 1'b0;
    else if (!evt_stall) evt_ok <= evt_valid;
  end

  always_ff @(posedge clk) begin
    if (!evt_stall) evt_q <= evt;
  end

  cvca_eval #(
    .MAX_BUSES (MAX_BUSES),
    .MAX_STEPS (MAX_STEPS)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .evt_ok     (evt_ok),
    .evt_q      (evt_q),
    .emit_free  (emit_free),
    .fire       (fire),
    .batch_load (batch_load),
    .batch      (batch)
  );

  cvca_emit #(
    .MAX_BUSES (MAX_BUSES)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .batch_load (batch_load),
    .batch      (batch),
    .emit_free  (emit_free),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd)
  );

endmodule

FILE: tb/core_voltage_cap_arbiter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// core_voltage_cap_arbiter_test
// Self-checking bench for the core-voltage cap arbiter. A local model of the
// requester counts, levels and rounded cap predicts every rate command; the
// bench walks the step rounding, bus ordering and table limits by hand, drives
// random cap events against random configurations with random stalls on both
// channels, then runs a reference count to saturation and unstalled traffic.
// ----------------------------------------------------------------------------
module core_voltage_cap_arbiter_test;
  import cvca_pkg::*;

  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        evt_valid = 1'b0;
  logic        evt_stall;
  cvca_evt_t   evt = '0;
  logic        cmd_valid;
  logic        cmd_stall = 1'b0;
  cvca_cmd_t   cmd;

  // model configuration
  logic [15:0]  cfg_nominal;
  logic [127:0] cfg_steps;
  logic [3:0]   cfg_bus_count;
  logic [7:0]   cfg_mask;
  // model state
  logic [7:0]   kern_cnt;
  logic [15:0]  kern_lvl;
  logic [7:0]   usr_cnt;
  logic [15:0]  usr_lvl;
  logic [15:0]  cap_lvl;
  logic [1:0]   active_reqs;

  cvca_cmd_t pending_cmds[$];
  cvca_cmd_t want_cmd;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;

  core_voltage_cap_arbiter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d rate commands outstanding", $time, pending_cmds.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    cmd_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // ---- cap model ----------------------------------------------------------

  function automatic logic [15:0] step_at(int k);
    return cfg_steps[16*k +: 16];
  endfunction

  // Recompute the cap and queue the rate commands that a change causes
  function automatic void settle_cap();
    logic [15:0] target;
    logic [15:0] new_cap;
    int          nb;
    int          j;
    int          chosen;
    int          bus;
    int          n_present;
    int          n_sent;
    bit          down;
    cvca_cmd_t   c;
    target = cfg_nominal;
    if (kern_cnt != 0 && kern_lvl < target) target = kern_lvl;
    if (usr_cnt != 0 && usr_lvl < target) target = usr_lvl;
    if (target == cap_lvl) return;
    nb = (int'(cfg_bus_count) > MAX_BUSES_DEF) ? MAX_BUSES_DEF : int'(cfg_bus_count);
    if (nb == 0) return;
    for (j = 0; j < MAX_STEPS_DEF; j++) begin
      if (step_at(j) == 16'd0 || target < step_at(j)) break;
    end
    chosen = (j == 0) ? 0 : j - 1;
    new_cap = step_at(chosen);
    if (new_cap != cap_lvl) begin
      down = (new_cap < cap_lvl);
      n_present = 0;
      for (int k = 0; k < nb; k++) n_present += cfg_mask[k];
      n_sent = 0;
      for (int k = 0; k < nb; k++) begin
        bus = down ? k : nb - 1 - k;
        if (cfg_mask[bus]) begin
          n_sent++;
          c.bus_index  = bus[2:0];
          c.step_index = chosen[2:0];
          c.cap_mv     = new_cap;
          c.last       = (n_sent == n_present);
          pending_cmds.push_back(c);
        end
      end
    end
    cap_lvl = new_cap;
  endfunction

  function automatic void apply_cap_event(cvca_evt_t e);
    case (e.action)
      ACT_KERNEL_EN: begin
        if (kern_cnt != 8'hFF) begin
          kern_cnt++;
          if (kern_cnt == 8'd1) begin
            if (active_reqs < 2'd3) active_reqs++;
            settle_cap();
          end
        end
      end
      ACT_KERNEL_DIS: begin
        if (kern_cnt != 8'd0) begin
          kern_cnt--;
          if (kern_cnt == 8'd0) begin
            if (active_reqs > 2'd0) active_reqs--;
            settle_cap();
          end
        end
      end
      ACT_KERNEL_SET: begin
        kern_lvl = e.level_mv;
        settle_cap();
      end
      ACT_USER_EN: begin
        if (usr_cnt != 8'hFF) begin
          usr_cnt++;
          if (usr_cnt == 8'd1) begin
            if (active_reqs < 2'd3) active_reqs++;
            settle_cap();
          end
        end
      end
      ACT_USER_DIS: begin
        if (usr_cnt != 8'd0) begin
          usr_cnt--;
          if (usr_cnt == 8'd0) begin
            if (active_reqs > 2'd0) active_reqs--;
            settle_cap();
          end
        end
      end
      ACT_USER_SET: begin
        usr_lvl = e.level_mv;
        settle_cap();
      end
      default: ;
    endcase
  endfunction

  // ---- result checking ----------------------------------------------------

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: rate command with none expected: bus %0d step %0d cap %0d last %0d",
                 $time, cmd.bus_index, cmd.step_index, cmd.cap_mv, cmd.last);
        mismatch_count++;
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (cmd.bus_index !== want_cmd.bus_index)
          report_mismatch("bus_index", want_cmd.bus_index, cmd.bus_index);
        if (cmd.step_index !== want_cmd.step_index)
          report_mismatch("step_index", want_cmd.step_index, cmd.step_index);
        if (cmd.cap_mv !== want_cmd.cap_mv)
          report_mismatch("cap_mv", want_cmd.cap_mv, cmd.cap_mv);
        if (cmd.last !== want_cmd.last)
          report_mismatch("last", want_cmd.last, cmd.last);
      end
    end
  end

  // ---- stimulus helpers ---------------------------------------------------

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_NOMINAL:   cfg_nominal = data[15:0];
      REG_STEP_LOW:  cfg_steps[63:0] = data;
      REG_STEP_HIGH: cfg_steps[127:64] = data;
      REG_BUS_COUNT: cfg_bus_count = data[3:0];
      REG_BUS_MASK:  cfg_mask = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_setup(logic [15:0] nominal, logic [127:0] steps,
                             logic [3:0] bus_count, logic [7:0] mask);
    write_reg(REG_NOMINAL, {48'd0, nominal});
    write_reg(REG_STEP_LOW, steps[63:0]);
    write_reg(REG_STEP_HIGH, steps[127:64]);
    write_reg(REG_BUS_COUNT, {60'd0, bus_count});
    write_reg(REG_BUS_MASK, {56'd0, mask});
  endtask

  // valid is held from item to item unless a gap is drawn
  task automatic send_event(logic [2:0] act, logic [15:0] lvl);
    cvca_evt_t e;
    e.action   = act;
    e.level_mv = lvl;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      evt_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    evt_valid <= 1'b1;
    evt       <= e;
    do @(posedge clk); while (evt_stall);
    apply_cap_event(e);
  endtask

  task automatic wait_for_idle();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'd0;
      2: return 16'hFFFF;
      3: return cfg_nominal;
      default: return step_at($urandom_range(0, 7)) + 16'($urandom_range(0, 4)) - 16'd2;
    endcase
  endfunction

  task automatic randomize_config();
    logic [15:0]  nominal;
    logic [127:0] steps;
    logic [3:0]   bus_count;
    logic [7:0]   mask;
    int           n_steps;
    int           mv;
    case ($urandom_range(0, 9))
      0: nominal = 16'd1;
      1: nominal = 16'hFFFF;
      2: nominal = 16'($urandom_range(1, 65535));
      default: nominal = 16'($urandom_range(400, 1500));
    endcase
    steps = '0;
    case ($urandom_range(0, 9))
      0: steps = {$urandom, $urandom, $urandom, $urandom};
      1: steps = '0;
      default: begin
        n_steps = $urandom_range(1, 8);
        mv = $urandom_range(300, 700);
        for (int k = 0; k < n_steps; k++) begin
          steps[16*k +: 16] = mv[15:0];
          mv += $urandom_range(50, 200);
        end
      end
    endcase
    case ($urandom_range(0, 9))
      0: bus_count = 4'd0;
      1: bus_count = 4'($urandom_range(9, 15));
      default: bus_count = 4'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0: mask = 8'h00;
      1: mask = 8'hFF;
      default: mask = 8'($urandom_range(0, 255));
    endcase
    write_setup(nominal, steps, bus_count, mask);
  endtask

  // ---- tests --------------------------------------------------------------

  // Reset config has no buses: nothing may come out whatever the requests
  task automatic test_empty_bus_table();
    send_event(ACT_KERNEL_DIS, 16'd0);
    send_event(ACT_KERNEL_EN, 16'd0);
    send_event(ACT_KERNEL_SET, 16'd500);
    send_event(ACT_USER_EN, 16'd0);
    send_event(ACT_USER_SET, 16'hFFFF);
    send_event(ACT_SPARE_6, 16'd100);
    send_event(ACT_SPARE_7, 16'hFFFF);
  endtask

  task automatic test_step_rounding();
    wait_for_idle();
    write_setup(16'd1200, {64'd0, 16'd1200, 16'd1000, 16'd800, 16'd600}, 4'd4, 8'b0000_1011);
    send_event(ACT_KERNEL_SET, 16'd950);   // between steps, rounds down
    send_event(ACT_KERNEL_SET, 16'd500);   // below the table, step 0
    send_event(ACT_KERNEL_SET, 16'hFFFF);  // back up to nominal, descending order
    send_event(ACT_KERNEL_SET, 16'd0);
    send_event(ACT_USER_SET, 16'd1000);    // rounds to the cap already held
    send_event(ACT_KERNEL_DIS, 16'd0);
    send_event(ACT_USER_SET, 16'd1000);    // unrounded cap unchanged
    send_event(ACT_USER_DIS, 16'd0);
    send_event(ACT_USER_DIS, 16'd0);
  endtask

  task automatic test_bus_table_limits();
    wait_for_idle();
    // full table with no terminator, bus count beyond the maximum
    write_setup(16'hFFFF, {16'd800, 16'd700, 16'd600, 16'd500, 16'd400, 16'd300, 16'd200,
                           16'd100}, 4'd15, 8'hFF);
    send_event(ACT_USER_EN, 16'd0);
    send_event(ACT_USER_SET, 16'hFFFF);
    wait_for_idle();
    write_reg(REG_BUS_COUNT, 64'd6);       // mask bits 6 and 7 now ignored
    send_event(ACT_USER_SET, 16'd250);
    wait_for_idle();
    write_reg(REG_STEP_LOW, 64'd0);        // table starting with zero
    write_reg(REG_STEP_HIGH, 64'd0);
    send_event(ACT_USER_SET, 16'd300);
    wait_for_idle();
    write_setup(16'd1, {128{1'b1}}, 4'd6, 8'hFF);
    send_event(ACT_USER_DIS, 16'd0);
    wait_for_idle();
    write_reg(REG_BUS_COUNT, 64'd0);
    send_event(ACT_USER_EN, 16'd0);
  endtask

  task automatic test_count_saturation();
    wait_for_idle();
    write_setup(16'd1200, {64'd0, 16'd0, 16'd1200, 16'd800, 16'd400}, 4'd3, 8'b0000_0111);
    while (usr_cnt != 8'd0) send_event(ACT_USER_DIS, 16'd0);
    send_event(ACT_USER_SET, 16'd500);
    repeat (257) send_event(ACT_USER_EN, 16'd0);
    repeat (2) send_event(ACT_USER_DIS, 16'd0);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int pick;
    wait_for_idle();
    randomize_config();
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 29) == 0) wait_for_idle();
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_event((pick < 3) ? ACT_SPARE_6 : ACT_SPARE_7, 16'($urandom));
      end else begin
        if (pick < 52)
          send_event($urandom_range(0, 1) ? ACT_KERNEL_SET : ACT_USER_SET, pick_level());
        else if (pick < 77)
          send_event($urandom_range(0, 1) ? ACT_KERNEL_EN : ACT_USER_EN, 16'($urandom));
        else
          send_event($urandom_range(0, 1) ? ACT_KERNEL_DIS : ACT_USER_DIS, 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    cfg_nominal   = NOMINAL_RESET;
    cfg_steps     = '0;
    cfg_bus_count = 4'd0;
    cfg_mask      = 8'd0;
    kern_cnt      = 8'd0;
    usr_cnt       = 8'd0;
    active_reqs   = 2'd0;
    kern_lvl      = NOMINAL_RESET;
    usr_lvl       = NOMINAL_RESET;
    cap_lvl       = NOMINAL_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 19;
    rx_idle_pct = 72;
    test_empty_bus_table();
    test_step_rounding();
    test_bus_table_limits();
    repeat (3) test_random_traffic(14);

    tx_idle_pct = 72;
    rx_idle_pct = 19;
    repeat (3) test_random_traffic(14);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_count_saturation();
    repeat (3) test_random_traffic(14);

    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
